/* hw/rtl/sitdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sitdt_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned NDIGITS  = 10;
    localparam int unsigned BCD_W    = 4 * NDIGITS;
    localparam int unsigned STEPS    = 4;
    localparam int unsigned NSTAGES  = VALUE_W / STEPS;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dab;

    // Four shift-and-add-3 steps.
    function automatic t_dab dabble4(input t_dab a);
        t_dab r;
        r = a;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < NDIGITS; d++) begin
                if (r.bcd[4*d +: 4] >= 4'd5) begin
                    r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
                end
            end
            r = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

    // Index of the highest nonzero digit, zero if none.
    function automatic logic [POS_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
        logic [POS_W-1:0] t;
        t = '0;
        for (int d = 0; d < NDIGITS; d++) begin
            if (bcd[4*d +: 4] != 4'd0) begin
                t = POS_W'(d);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_text_top.sv */
// Converts a signed 32-bit integer on the slave stream into its decimal ASCII
// text on the master stream, most significant character first, with tlast on
// the final character. Negative values start with '-', there are no leading
// zeros, and zero gives the single character '0'. The conversion runs through
// a nine-stage pipeline (one input register, then eight stages of four
// shift-and-add-3 steps each) that accepts one value per cycle while the
// serializer does not hold it back. A character serializer then emits one
// character per cycle while the master side is ready: each value gives 1 to
// 11 characters, and that character count sets the sustained rate while the
// master side takes every cycle.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_text_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] character
    output logic             o_m_tlast
);

    localparam int unsigned NS = sitdt_pkg::NSTAGES;

    logic                            r_vld [0:NS];
    logic                            r_neg [0:NS];
    sitdt_pkg::t_dab                 r_dab [0:NS];
    logic                            w_rdy [0:NS+1];

    logic                            r_ser_vld;
    logic                            r_ser_sign;
    logic [sitdt_pkg::POS_W-1:0]     r_ser_pos;
    logic [sitdt_pkg::BCD_W-1:0]     r_ser_bcd;
    logic                            w_last;
    logic                            w_xfer;

    assign w_last = !r_ser_sign && (r_ser_pos == '0);
    assign w_xfer = r_ser_vld && i_m_tready;
    assign w_rdy[NS+1] = !r_ser_vld || (i_m_tready && w_last);

    genvar k;
    generate
        for (k = 0; k <= NS; k++) begin : g_rdy
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    endgenerate

    assign o_s_tready = w_rdy[0];

    // load magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_vld[0] <= i_s_tvalid;
        end
        if (w_rdy[0]) begin
            r_neg[0]     <= i_s_tdata[31];
            r_dab[0].bcd <= '0;
            r_dab[0].bin <= i_s_tdata[31] ? (32'd0 - i_s_tdata) : i_s_tdata;
        end
    end

    generate
        for (k = 1; k <= NS; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
                if (w_rdy[k]) begin
                    r_neg[k] <= r_neg[k-1];
                    r_dab[k] <= sitdt_pkg::dabble4(r_dab[k-1]);
                end
            end
        end
    endgenerate

    // serialize characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
        end else if (w_rdy[NS+1]) begin
            r_ser_vld <= r_vld[NS];
        end
        if (w_rdy[NS+1]) begin
            r_ser_sign <= r_neg[NS];
            r_ser_bcd  <= r_dab[NS].bcd;
            r_ser_pos  <= sitdt_pkg::top_digit(r_dab[NS].bcd);
        end else if (w_xfer) begin
            if (r_ser_sign) begin
                r_ser_sign <= 1'b0;
            end else begin
                r_ser_pos <= r_ser_pos - 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_ser_vld;
    assign o_m_tlast  = w_last;
    assign o_m_tdata  = r_ser_sign ? sitdt_pkg::CHAR_MINUS
                      : (sitdt_pkg::CHAR_ZERO | {4'd0, r_ser_bcd[4*r_ser_pos +: 4]});

endmodule

`default_nettype wire

/* sim/signed_int_to_decimal_text_top_tb.sv */
`timescale 1ns / 1ps

module signed_int_to_decimal_text_top_tb;

    localparam int RANDOM_ITEMS   = 430;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;

    typedef struct packed {
        logic [sitdt_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } text_char_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    logic [31:0] pending_values_q[$];
    text_char_t  expected_text_q[$];

    int  error_count    = 0;
    int  values_sent    = 0;
    int  stall_cycles   = 0;
    int  send_idle_pct  = 12;
    int  recv_idle_pct  = 46;
    bit  value_accepted = 1'b0;

    logic [31:0] directed_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd100, 32'd12345, 32'd999999999, 32'd1000000000, -32'sd999999999,
        -32'sd1000000000, 32'd2147483647, -32'sd2147483647, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd1000, -32'sd7
    };

    signed_int_to_decimal_text_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [31:0] value
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [7:0] character
        .o_m_tlast  (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    task automatic append_decimal_text(input logic [31:0] value);
        logic [31:0] magnitude;
        logic [3:0]  digits [10];
        int          ndig;
        text_char_t  c;
        magnitude = value[31] ? (32'd0 - value) : value;
        for (ndig = 0; ndig == 0 || magnitude != 0; ndig++) begin
            digits[ndig] = 4'(magnitude % 32'd10);
            magnitude    = magnitude / 32'd10;
        end
        if (value[31]) begin
            c.ch   = sitdt_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text_q.push_back(c);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            c.ch   = sitdt_pkg::CHAR_ZERO + 8'(digits[i]);
            c.last = (i == 0);
            expected_text_q.push_back(c);
        end
    endtask

    // Driver: hold an offered value until its transfer, then maybe idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (!i_s_tvalid || value_accepted) begin
                if (pending_values_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_values_q[0];
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor: capture input transfers, check output transfers.
    always @(posedge i_clk) begin
        value_accepted = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                append_decimal_text(i_s_tdata);
                void'(pending_values_q.pop_front());
                value_accepted = 1'b1;
                values_sent++;
                if (values_sent < PHASE_ITEMS) begin
                    send_idle_pct = 12;
                    recv_idle_pct = 46;
                end else if (values_sent < 2 * PHASE_ITEMS) begin
                    send_idle_pct = 46;
                    recv_idle_pct = 12;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_text_q.size() == 0) begin
                    $error("unexpected character transfer: character %h last %b",
                           o_m_tdata, o_m_tlast);
                    error_count++;
                end else begin
                    text_char_t exp_c;
                    exp_c = expected_text_q.pop_front();
                    if (o_m_tdata !== exp_c.ch) begin
                        $error("character: expected %h actual %h", exp_c.ch, o_m_tdata);
                        error_count++;
                    end
                    if (o_m_tlast !== exp_c.last) begin
                        $error("last: expected %b actual %b", exp_c.last, o_m_tlast);
                        error_count++;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned ndigits;
        longint      lo;
        longint      hi;
        logic [31:0] v;
        foreach (directed_values[i]) begin
            pending_values_q.push_back(directed_values[i]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(9, 0) < 7) begin
                // Spread over every digit count, both signs.
                ndigits = $urandom_range(10, 1);
                lo = (ndigits == 1) ? 0 : 10 ** (ndigits - 1);
                hi = (ndigits == 10) ? 64'd2147483647 : 10 ** ndigits - 1;
                v  = $urandom_range(32'(hi), 32'(lo));
                if ($urandom_range(1, 0)) begin
                    v = 32'd0 - v;
                end
            end else begin
                v = $urandom;
            end
            pending_values_q.push_back(v);
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_values_q.size() != 0 || expected_text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
